// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the limiter RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSPL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define LSPL_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define LSPL_ASSERT(lbl, clk, rst_n, prop)
`define LSPL_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/lspl_pkg.sv =====
// Constants shared by the look-ahead stereo peak limiter.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none
package lspl_pkg;
    localparam int LOOKAHEAD  = 64;
    localparam int DLY_DEPTH  = LOOKAHEAD + 1;
    localparam int WIN_DEPTH  = LOOKAHEAD + 2;
    localparam int DLY_AW     = $clog2(DLY_DEPTH);
    localparam int WIN_AW     = $clog2(WIN_DEPTH);
    localparam int CNT_W      = $clog2(WIN_DEPTH + 1);
    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 25;
    localparam int COEFF_W    = 24;
    localparam int STAMP_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [GAIN_W-1:0]     UNITY_GAIN = 25'd16777216;
    localparam logic [SAMPLE_W-1:0]   FULL_SCALE = 24'd8388608;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIMITER_ON = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 2'd3;

    localparam logic [CFG_DATA_W-1:0] RST_CEILING = 24'd7919357;
    localparam logic [COEFF_W-1:0]    RST_ATTACK  = 24'd16044700;
    localparam logic [COEFF_W-1:0]    RST_RELEASE = 24'd16774303;
endpackage
`default_nettype wire

// ===== hw/rtl/lspl_in_if.sv =====
// Input channel: one stereo frame per transaction.
// Depends on lspl_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface lspl_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lspl_pkg::SAMPLE_W-1:0]  left_sample;
    logic signed [lspl_pkg::SAMPLE_W-1:0]  right_sample;
    modport source (output valid, left_sample, right_sample, input ready);
    modport sink (input valid, left_sample, right_sample, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lspl_out_if.sv =====
// Output channel: one limited frame and its gain per transaction.
// Depends on lspl_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface lspl_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lspl_pkg::SAMPLE_W-1:0]  left_result;
    logic signed [lspl_pkg::SAMPLE_W-1:0]  right_result;
    logic [lspl_pkg::GAIN_W-1:0]           applied_gain;
    modport source (output valid, left_result, right_result, applied_gain, input ready);
    modport sink (input valid, left_result, right_result, applied_gain, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lspl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lspl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lookahead_stereo_peak_limiter_core.sv =====
// Look-ahead stereo peak limiter, top level.
// Depends on lspl_pkg, lspl_in_if, lspl_out_if, lspl_ram and assert_macros.svh.
//
// Usage: frames enter on i_in (valid/ready), one transaction per stereo pair,
// and leave on o_out with the gain that was applied; every frame gives exactly
// one result. Configuration is written on i_cfg_* while the block is idle.
// The block handles one frame at a time; i_in.ready is high only when idle.
// When limiting, an accepted frame passes through the peak state, the restoring
// divider when the peak exceeds the ceiling, a read and a compare per deque
// entry popped from the back and for a remaining entry that is compared and
// kept, the push, a read and a compare per expired entry removed from the front,
// then smoothing and the two sample multiplies. The window RAM has one read port,
// so every deque step costs a read and a compare. The sequencer returns to idle
// as the result is registered. In bypass the peak state goes straight to finish.
// A result sits in the output register while the next frame is accepted; if
// the receiver still stalls when the next result is ready, the sequencer holds
// in its last state until the register frees.
// Reset is synchronous; the delay line reads as silence until it has filled
// once (a fill flag, no clearing pass), the gain starts at unity.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lookahead_stereo_peak_limiter_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    lspl_in_if.sink                                 i_in,
    lspl_out_if.source                              o_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [lspl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [lspl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    localparam int SW = lspl_pkg::SAMPLE_W;
    localparam int GW = lspl_pkg::GAIN_W;
    localparam int PW = GW + lspl_pkg::COEFF_W;
    localparam int DW = lspl_pkg::DLY_AW;
    localparam int WW = lspl_pkg::WIN_AW;
    localparam int TW = lspl_pkg::STAMP_W;

    typedef enum logic [3:0] {
        S_IDLE, S_PEAK, S_DIV, S_POP_RD, S_POP_CHK, S_PUSH, S_EXP_RD, S_EXP_CHK,
        S_SMOOTH, S_SM_ADD, S_MUL_L, S_MUL_R, S_FINISH
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic                          r_on;
    logic [SW-1:0]                 r_ceiling;
    logic [lspl_pkg::COEFF_W-1:0]  r_attack;
    logic [lspl_pkg::COEFF_W-1:0]  r_release;

    // Datapath and bookkeeping registers.
    logic signed [SW-1:0] r_l, r_r, r_dl, r_dr, r_res_l;
    logic [DW-1:0]        r_wi;
    logic                 r_dly_full, r_rd_valid, r_byp, r_fall;
    logic [SW-1:0]        r_rem, r_quo, r_peak;
    logic [4:0]           r_div_cnt;
    logic [GW-1:0]        r_des, r_target, r_smooth;
    logic [WW-1:0]        r_head, r_tail, r_back;
    logic [lspl_pkg::CNT_W-1:0] r_cnt;
    logic [TW-1:0]        r_fc;
    logic [PW-1:0]        r_prod;
    logic                 r_ov;
    logic signed [SW-1:0] r_ol, r_or;
    logic [GW-1:0]        r_og;

    // RAM ports.
    logic                 dly_we;
    logic [DW-1:0]        dly_raddr;
    logic [2*SW-1:0]      dly_rdata;
    logic                 win_we;
    logic [WW-1:0]        win_raddr;
    logic [GW+TW-1:0]     win_rdata;

    logic                 in_acc;
    logic [DW-1:0]        rd_idx;
    logic [WW-1:0]        back_idx, tail_nx, head_nx;
    logic [SW-1:0]        ceil_c, mag_l, mag_r, peak;
    logic signed [SW+1:0] pos_bound, neg_bound;
    logic [SW:0]          div_sh;
    logic [GW-1:0]        win_gain, diff, adj;
    logic [TW-1:0]        win_stamp;
    logic [GW:0]          sm_sum;
    logic signed [SW-1:0] clip_r;
    logic                 out_free;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // Ring indexes.
    assign rd_idx   = (r_wi == DW'(lspl_pkg::DLY_DEPTH - 1)) ? '0 : r_wi + 1'b1;
    assign back_idx = (r_tail == '0) ? WW'(lspl_pkg::WIN_DEPTH - 1) : r_tail - 1'b1;
    assign tail_nx  = (r_tail == WW'(lspl_pkg::WIN_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign head_nx  = (r_head == WW'(lspl_pkg::WIN_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Ceiling, clip bounds, magnitudes and peak.
    assign ceil_c    = (r_ceiling > lspl_pkg::FULL_SCALE) ? lspl_pkg::FULL_SCALE : r_ceiling;
    assign pos_bound = (ceil_c >= lspl_pkg::FULL_SCALE)
                     ? $signed({2'b00, lspl_pkg::FULL_SCALE - 1'b1})
                     : $signed({2'b00, ceil_c});
    assign neg_bound = -$signed({2'b00, ceil_c});
    assign mag_l     = r_l[SW-1] ? SW'(-r_l) : SW'(r_l);
    assign mag_r     = r_r[SW-1] ? SW'(-r_r) : SW'(r_r);
    assign peak      = (mag_l > mag_r) ? mag_l : mag_r;
    assign div_sh    = {r_rem, 1'b0};
    assign win_gain  = win_rdata[GW+TW-1:TW];
    assign win_stamp = win_rdata[TW-1:0];
    assign diff      = (r_target < r_smooth) ? r_smooth - r_target : r_target - r_smooth;
    assign adj       = r_prod[PW-1:lspl_pkg::COEFF_W];
    assign sm_sum    = r_fall ? {1'b0, r_target} + {1'b0, adj}
                              : {1'b0, r_target} - {1'b0, adj};

    // Round half away from zero, restore sign, clip.
    function automatic logic signed [SW-1:0] scale_clip(
        input logic neg, input logic [PW-1:0] prod,
        input logic signed [SW+1:0] pb, input logic signed [SW+1:0] nb);
        logic [PW-1:0]        rnd;
        logic signed [SW+1:0] v;
        rnd = prod + PW'(1 << (lspl_pkg::COEFF_W - 1));
        v   = $signed({1'b0, rnd[PW-2:lspl_pkg::COEFF_W]});
        if (neg) v = -v;
        if (v > pb) v = pb;
        if (v < nb) v = nb;
        return v[SW-1:0];
    endfunction

    assign clip_r = scale_clip(r_dr[SW-1], r_prod, pos_bound, neg_bound);

    // Memory port control.
    always_comb begin
        dly_we    = in_acc;
        dly_raddr = rd_idx;
        win_we    = (r_state == S_PUSH);
        win_raddr = (r_state == S_POP_RD) ? back_idx : r_head;
    end

    lspl_ram #(.WIDTH(2 * SW), .DEPTH(lspl_pkg::DLY_DEPTH)) u_dly (
        .i_clk   (i_clk),
        .i_we    (dly_we),
        .i_waddr (r_wi),
        .i_wdata ({i_in.left_sample, i_in.right_sample}),
        .i_raddr (dly_raddr),
        .o_rdata (dly_rdata)
    );

    lspl_ram #(.WIDTH(GW + TW), .DEPTH(lspl_pkg::WIN_DEPTH)) u_win (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (r_tail),
        .i_wdata ({r_des, r_fc}),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

    // Sequencer, datapath and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_on       <= 1'b1;
            r_ceiling  <= lspl_pkg::RST_CEILING;
            r_attack   <= lspl_pkg::RST_ATTACK;
            r_release  <= lspl_pkg::RST_RELEASE;
            r_wi       <= '0;
            r_dly_full <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_cnt      <= '0;
            r_fc       <= '0;
            r_smooth   <= lspl_pkg::UNITY_GAIN;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lspl_pkg::CFG_LIMITER_ON: r_on      <= i_cfg_wdata[0];
                    lspl_pkg::CFG_CEILING:    r_ceiling <= i_cfg_wdata;
                    lspl_pkg::CFG_ATTACK:     r_attack  <= i_cfg_wdata;
                    lspl_pkg::CFG_RELEASE:    r_release <= i_cfg_wdata;
                    default: ;
                endcase
            end
            // The output register fills when a result is finished and empties when taken.
            if (r_state == S_FINISH && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_l        <= i_in.left_sample;
                        r_r        <= i_in.right_sample;
                        r_rd_valid <= r_dly_full || (rd_idx == '0);
                        r_wi       <= rd_idx;
                        if (r_wi == DW'(lspl_pkg::DLY_DEPTH - 1)) begin
                            r_dly_full <= 1'b1;
                        end
                        r_state <= S_PEAK;
                    end
                end
                S_PEAK: begin
                    r_dl   <= r_rd_valid ? dly_rdata[2*SW-1:SW] : '0;
                    r_dr   <= r_rd_valid ? dly_rdata[SW-1:0] : '0;
                    r_peak <= peak;
                    r_byp  <= !r_on;
                    r_rem  <= ceil_c;
                    r_quo  <= '0;
                    r_div_cnt <= '0;
                    r_des  <= lspl_pkg::UNITY_GAIN;
                    if (!r_on) begin
                        r_state <= S_FINISH;
                    end else if (peak > ceil_c) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_POP_RD;
                    end
                end
                S_DIV: begin
                    // One quotient bit per cycle; the remainder stays below the peak.
                    if (div_sh >= {1'b0, r_peak}) begin
                        r_rem <= SW'(div_sh - {1'b0, r_peak});
                        r_quo <= {r_quo[SW-2:0], 1'b1};
                    end else begin
                        r_rem <= div_sh[SW-1:0];
                        r_quo <= {r_quo[SW-2:0], 1'b0};
                    end
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == 5'(SW - 1)) begin
                        r_state <= S_POP_RD;
                    end
                end
                S_POP_RD: begin
                    if (r_div_cnt == 5'(SW)) begin
                        r_des     <= {1'b0, r_quo};
                        r_div_cnt <= '0;
                    end
                    r_back  <= back_idx;
                    r_state <= (r_cnt != '0) ? S_POP_CHK : S_PUSH;
                end
                S_POP_CHK: begin
                    // Drop entries from the back that are no smaller than the new gain.
                    if (win_gain >= r_des) begin
                        r_tail  <= r_back;
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_POP_RD;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    r_tail <= tail_nx;
                    if (r_cnt < lspl_pkg::CNT_W'(lspl_pkg::WIN_DEPTH)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_state <= S_EXP_RD;
                end
                S_EXP_RD: begin
                    r_state <= S_EXP_CHK;
                end
                S_EXP_CHK: begin
                    // Expire stale entries from the front; the head holds the minimum.
                    if (r_cnt != '0 && (r_fc - win_stamp) >= TW'(lspl_pkg::LOOKAHEAD)) begin
                        r_head  <= head_nx;
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_EXP_RD;
                    end else begin
                        r_target <= win_gain;
                        r_fc     <= r_fc + 1'b1;
                        r_state  <= S_SMOOTH;
                    end
                end
                S_SMOOTH: begin
                    r_fall  <= (r_target < r_smooth);
                    r_prod  <= diff * ((r_target < r_smooth) ? r_attack : r_release);
                    r_state <= S_SM_ADD;
                end
                S_SM_ADD: begin
                    r_smooth <= (sm_sum > {1'b0, lspl_pkg::UNITY_GAIN})
                              ? lspl_pkg::UNITY_GAIN : sm_sum[GW-1:0];
                    r_state  <= S_MUL_L;
                end
                S_MUL_L: begin
                    r_prod  <= PW'($unsigned(r_dl[SW-1] ? -r_dl : r_dl)) * PW'(r_smooth);
                    r_state <= S_MUL_R;
                end
                S_MUL_R: begin
                    r_res_l <= scale_clip(r_dl[SW-1], r_prod, pos_bound, neg_bound);
                    r_prod  <= PW'($unsigned(r_dr[SW-1] ? -r_dr : r_dr)) * PW'(r_smooth);
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_ol    <= r_byp ? r_dl : r_res_l;
                        r_or    <= r_byp ? r_dr : clip_r;
                        r_og    <= r_smooth;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.left_result  = r_ol;
    assign o_out.right_result = r_or;
    assign o_out.applied_gain = r_og;

    // Consistency checks on the sequencer, the deque, the gain and the delay-line index.
    `LSPL_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > lspl_pkg::CNT_W'(lspl_pkg::WIN_DEPTH))
    `LSPL_NEVER(a_gain_range, i_clk, i_rst_n, r_smooth > lspl_pkg::UNITY_GAIN)
    `LSPL_NEVER(a_wi_range, i_clk, i_rst_n, r_wi > DW'(lspl_pkg::DLY_DEPTH - 1))
    `LSPL_ASSERT(a_busy_after_accept, i_clk, i_rst_n, in_acc |=> !i_in.ready)
endmodule
`default_nettype wire

// ===== dv/lspl_tb_if.sv =====
// Testbench-side types for the limiter: the limited frame as it leaves the block.
// Depends on lspl_pkg; the RTL interfaces are reused, so this file only holds shared types.
`timescale 1ns / 1ps
package lspl_tb_pkg;
    import lspl_pkg::*;

    // One limited frame as it leaves the block.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [GAIN_W-1:0]          gain;
    } limited_frame_t;
endpackage

// ===== dv/tb_lookahead_stereo_peak_limiter_core.sv =====
// Regression for the look-ahead stereo peak limiter: directed and random frames with a
// bit-true limiter predictor in a scoreboard class. Depends on lspl_pkg, the channel
// interfaces and lspl_tb_pkg.
`timescale 1ns / 1ps
module tb_lookahead_stereo_peak_limiter_core;
    import lspl_pkg::*;
    import lspl_tb_pkg::*;

    // Bit-true limiter predictor with the queue of frames still owed by the block.
    class limiter_scoreboard;
        logic        on_q;
        logic [23:0] ceiling_q, attack_q, release_q;
        logic signed [23:0] dly_l [DLY_DEPTH];
        logic signed [23:0] dly_r [DLY_DEPTH];
        int unsigned wr_pos;
        logic [24:0] win_gain [WIN_DEPTH];
        logic [31:0] win_stamp [WIN_DEPTH];
        int unsigned head, tail, count;
        logic [31:0] frame_no;
        logic [24:0] smooth;
        limited_frame_t owed_frames [$];
        int errors;
        int checked;

        function new();
            on_q = 1'b1;
            ceiling_q = RST_CEILING;
            attack_q = RST_ATTACK;
            release_q = RST_RELEASE;
            for (int i = 0; i < DLY_DEPTH; i++) begin
                dly_l[i] = '0;
                dly_r[i] = '0;
            end
            for (int i = 0; i < WIN_DEPTH; i++) begin
                win_gain[i] = UNITY_GAIN;
                win_stamp[i] = '0;
            end
            wr_pos = 0;
            head = 0;
            tail = 0;
            count = 0;
            frame_no = '0;
            smooth = UNITY_GAIN;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LIMITER_ON: on_q = data[0];
                CFG_CEILING:    ceiling_q = data;
                CFG_ATTACK:     attack_q = data;
                CFG_RELEASE:    release_q = data;
                default: ;
            endcase
        endfunction

        // Minimum desired gain over the look-ahead window, kept as a monotonic deque.
        function logic [24:0] window_floor(logic [24:0] g);
            int unsigned back;
            while (count > 0) begin
                back = (tail == 0) ? WIN_DEPTH - 1 : tail - 1;
                if (win_gain[back] >= g) begin
                    tail = back;
                    count--;
                end else begin
                    break;
                end
            end
            win_gain[tail] = g;
            win_stamp[tail] = frame_no;
            tail = (tail + 1 >= WIN_DEPTH) ? 0 : tail + 1;
            if (count < WIN_DEPTH) count++;
            while (count > 0 && (frame_no - win_stamp[head]) >= 32'(LOOKAHEAD)) begin
                head = (head + 1 >= WIN_DEPTH) ? 0 : head + 1;
                count--;
            end
            frame_no++;
            return win_gain[head];
        endfunction

        function logic signed [23:0] scale_sample(logic signed [23:0] s, logic [24:0] g,
                                                  longint pos_lim, longint neg_lim);
            longint mag, m, v;
            mag = (s < 0) ? -longint'(s) : longint'(s);
            m = (mag * longint'(g) + 64'h800000) >>> 24;
            v = (s < 0) ? -m : m;
            if (v > pos_lim) v = pos_lim;
            if (v < neg_lim) v = neg_lim;
            return v[23:0];
        endfunction

        // Note an accepted frame and queue the result it must produce.
        function void note_frame(logic signed [23:0] l, logic signed [23:0] r);
            int unsigned wi, rd;
            logic signed [23:0] dl, dr;
            longint ceil, al, ar, peak, pos_lim;
            logic [24:0] desired, target;
            longint diff;
            limited_frame_t f;
            wi = (wr_pos < DLY_DEPTH) ? wr_pos : 0;
            rd = (wi + 1 >= DLY_DEPTH) ? 0 : wi + 1;
            dly_l[wi] = l;
            dly_r[wi] = r;
            dl = dly_l[rd];
            dr = dly_r[rd];
            wr_pos = rd;
            if (!on_q) begin
                f.left = dl;
                f.right = dr;
                f.gain = smooth;
            end else begin
                ceil = (ceiling_q > FULL_SCALE) ? longint'(FULL_SCALE) : longint'(ceiling_q);
                al = (l < 0) ? -longint'(l) : longint'(l);
                ar = (r < 0) ? -longint'(r) : longint'(r);
                peak = (al > ar) ? al : ar;
                desired = UNITY_GAIN;
                if (peak > ceil) desired = 25'((ceil << 24) / peak);
                target = window_floor(desired);
                if (target < smooth) begin
                    diff = longint'(smooth) - longint'(target);
                    smooth = target + 25'((diff * longint'(attack_q)) >>> 24);
                end else begin
                    diff = longint'(target) - longint'(smooth);
                    smooth = target - 25'((diff * longint'(release_q)) >>> 24);
                end
                if (smooth > UNITY_GAIN) smooth = UNITY_GAIN;
                pos_lim = (ceil >= longint'(FULL_SCALE)) ? longint'(FULL_SCALE) - 1 : ceil;
                f.left = scale_sample(dl, smooth, pos_lim, -ceil);
                f.right = scale_sample(dr, smooth, pos_lim, -ceil);
                f.gain = smooth;
            end
            owed_frames.push_back(f);
        endfunction

        // Compare one result with the oldest owed frame, field by field.
        function void check_frame(limited_frame_t got);
            limited_frame_t exp_f;
            if (owed_frames.size() == 0) begin
                $display("%0t: unexpected result l=%0d r=%0d g=%0d", $time,
                         got.left, got.right, got.gain);
                errors++;
                return;
            end
            exp_f = owed_frames.pop_front();
            checked++;
            if (got.left !== exp_f.left) begin
                $display("%0t: left expected %0d actual %0d", $time, exp_f.left, got.left);
                errors++;
            end
            if (got.right !== exp_f.right) begin
                $display("%0t: right expected %0d actual %0d", $time, exp_f.right, got.right);
                errors++;
            end
            if (got.gain !== exp_f.gain) begin
                $display("%0t: gain expected %0d actual %0d", $time, exp_f.gain, got.gain);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    lspl_in_if  in_ch ();
    lspl_out_if out_ch ();
    limiter_scoreboard sb;
    int frames_sent;
    int bypass_frames;
    bit sink_on;

    lookahead_stereo_peak_limiter_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Output side: random stall per result, checked at the rising edge.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!sink_on) begin
                out_ch.ready = 1'b0;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                repeat (stall) @(negedge i_clk);
                out_ch.ready = 1'b1;
                @(posedge i_clk);
                while (!out_ch.valid) @(posedge i_clk);
                sb.check_frame({out_ch.left_result, out_ch.right_result,
                                out_ch.applied_gain});
                @(negedge i_clk);
                out_ch.ready = 1'b0;
            end
        end
    end

    // Send one frame after a random gap unless no_gap is set; valid drops once the transaction is taken.
    task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        repeat (gap) @(negedge i_clk);
        in_ch.left_sample = l;
        in_ch.right_sample = r;
        in_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_frame(l, r);
        frames_sent++;
        if (!sb.on_q) bypass_frames++;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // Wait until every owed result has come, then let the block settle.
    task automatic drain();
        while (sb.owed_frames.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($urandom_range(0, 600000)) - 24'sd300000;
            default: return 24'($urandom);
        endcase
    endfunction

    // Settings between phases: register extremes, bypass on and off, and random values.
    task automatic new_settings(int phase);
        drain();
        case (phase % 6)
            0: begin
                write_reg(CFG_CEILING, 24'd528000);
                write_reg(CFG_ATTACK, 24'd0);
                write_reg(CFG_RELEASE, 24'hFFFFFF);
            end
            1: begin
                write_reg(CFG_CEILING, 24'd8388608);
                write_reg(CFG_ATTACK, 24'hFFFFFF);
                write_reg(CFG_RELEASE, 24'd0);
            end
            2: write_reg(CFG_LIMITER_ON, 24'd0);
            3: begin
                write_reg(CFG_LIMITER_ON, 24'd1);
                write_reg(CFG_CEILING, 24'($urandom_range(528000, 8388608)));
            end
            4: write_reg(CFG_CEILING, 24'($urandom_range(0, 24'hFFFFFF)));
            default: begin
                write_reg(CFG_CEILING, 24'($urandom_range(528000, 8388608)));
                write_reg(CFG_ATTACK, 24'($urandom));
                write_reg(CFG_RELEASE, 24'($urandom));
            end
        endcase
    endtask

    initial begin
        logic signed [23:0] l, r;
        int burst;
        sb = new();
        frames_sent = 0;
        bypass_frames = 0;
        sink_on = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_LIMITER_ON;
        i_cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.left_sample = '0;
        in_ch.right_sample = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        sink_on = 1'b1;

        // Directed: field extremes, silence, a run of full-scale peaks, then bypass.
        send_frame(24'sh7FFFFF, 24'sh800000, 0);
        send_frame(24'sh800000, 24'sh000000, 0);
        send_frame(24'sh000000, 24'sh7FFFFF, 0);
        send_frame(24'sh000001, 24'shFFFFFF, 0);
        send_frame(24'sh000000, 24'sh000000, 0);
        send_frame(24'sh555555, 24'shAAAAAA, 0);
        for (int i = 0; i < 8; i++) send_frame(24'sh7FFFFF, 24'sh7FFFFF, 1);
        drain();
        write_reg(CFG_CEILING, 24'd0);
        send_frame(24'sh000000, 24'sh000000, 0);
        send_frame(24'sh000010, 24'sh000000, 0);
        drain();
        write_reg(CFG_CEILING, 24'hFFFFFF);
        send_frame(24'sh7FFFFF, 24'sh800000, 0);
        drain();
        write_reg(CFG_LIMITER_ON, 24'd0);
        send_frame(24'sh7FFFFF, 24'sh800000, 0);
        send_frame(24'sh123456, 24'shEDCBA9, 0);
        drain();
        write_reg(CFG_LIMITER_ON, 24'd1);
        write_reg(CFG_CEILING, RST_CEILING);

        // Random phases: bursts of loud transients over quiet bed, then settle.
        for (int phase = 0; frames_sent < 1850; phase++) begin
            new_settings(phase);
            burst = $urandom_range(100, 260);
            for (int i = 0; i < burst && frames_sent < 1850; i++) begin
                if ($urandom_range(0, 9) < 7) begin
                    l = 24'($urandom_range(0, 400000)) - 24'sd200000;
                    r = 24'($urandom_range(0, 400000)) - 24'sd200000;
                    if ($urandom_range(0, 15) == 0) l = rand_sample();
                    if ($urandom_range(0, 15) == 0) r = rand_sample();
                end else begin
                    l = rand_sample();
                    r = rand_sample();
                end
                send_frame(l, r, $urandom_range(0, 4) == 0);
            end
        end
        drain();
        $display("Checked %0d limited frames from %0d sent, %0d in bypass, over several",
                 sb.checked, frames_sent, bypass_frames);
        $display("ceiling and smoother settings including the register extremes.");
        if (sb.errors == 0 && sb.owed_frames.size() == 0) begin
            $display("lookahead_stereo_peak_limiter_core regression: pass");
        end else begin
            $display("lookahead_stereo_peak_limiter_core regression: fail");
        end
        $finish;
    end

    // Hang guard, well beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("lookahead_stereo_peak_limiter_core regression: fail");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lspl_pkg.sv
hw/rtl/lspl_in_if.sv
hw/rtl/lspl_out_if.sv
hw/rtl/lspl_ram.sv
hw/rtl/lookahead_stereo_peak_limiter_core.sv
dv/lspl_tb_if.sv
dv/tb_lookahead_stereo_peak_limiter_core.sv
